[hw/rtl/jls_pkg.sv]
`default_nettype none
package jls_pkg;

	// Sizing of the solver.
	localparam int MAX_DIM   = 8;
	localparam int FRAC_BITS = 16;

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int DIV_W  = 32 + FRAC_BITS;
	localparam int ACC_W  = 64 - FRAC_BITS + CNT_W;

	// Commands.
	localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
	localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
	localparam logic [1:0] CMD_SOLVE    = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_CONVERGED = 2'd0;
	localparam logic [1:0] STAT_LIMIT     = 2'd1;
	localparam logic [1:0] STAT_ZERO_DIAG = 2'd2;

	// Register indexes.
	localparam logic [1:0] REG_DIMENSION = 2'd0;
	localparam logic [1:0] REG_TOLERANCE = 2'd1;
	localparam logic [1:0] REG_ITER_LIM  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DG_ADDR,
		ST_DG_CHK,
		ST_MAC_ADDR,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_NUM,
		ST_DIV,
		ST_UPD,
		ST_SWEEP_END,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/jls_ram.sv]
`default_nettype none
module jls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hw/rtl/jls_divider.sv]
`default_nettype none
module jls_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [jls_pkg::DIV_W-1:0]    dividend,
	input  wire logic [31:0]                  divisor,
	output logic                              done,
	output logic      [jls_pkg::DIV_W-1:0]    quotient
);

	localparam int STEP_W = $clog2(jls_pkg::DIV_W + 1);

	logic [31:0]               rem_q;
	logic [jls_pkg::DIV_W-1:0] quo_q;
	logic [31:0]               div_q;
	logic [STEP_W-1:0]         step_q;
	logic                      run_q;
	logic                      done_q;
	logic [32:0]               trial;
	logic [32:0]               shifted;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, quo_q[jls_pkg::DIV_W-1]};
	assign trial   = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(jls_pkg::DIV_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the divider.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[jls_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[jls_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

[hw/rtl/jacobi_linear_solver.sv]
// Channel   Signals                                   Direction
// command   start, busy, cmd, row, col, value         in (accepted on start & !busy)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in (accepted on valid & ready)
// result    done, index, solution, status, last       out (one beat per cycle)
//
// A solve first reads each diagonal, row by row, then runs the sweeps, whose pace is set
// by the matrix RAM read per product and the bit-serial divider (48 steps per row).
// Results follow, one a cycle. Reset is asynchronous and clears control state; the
// matrix and vector stores are undefined until written. Results cannot be stalled;
// busy holds off new items.
`default_nettype none
module jacobi_linear_solver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [2:0]  row,
	input  wire logic [2:0]  col,
	input  wire logic signed [31:0] value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             done,
	output logic [2:0]       index,
	output logic signed [31:0] solution,
	output logic [1:0]       status,
	output logic             last
);

	localparam int IW  = jls_pkg::IDX_W;
	localparam int CW  = jls_pkg::CNT_W;
	localparam int AW  = jls_pkg::ADDR_W;
	localparam int DW  = jls_pkg::DIV_W;
	localparam int AC  = jls_pkg::ACC_W;
	localparam int FB  = jls_pkg::FRAC_BITS;
	localparam int MD  = jls_pkg::MAX_DIM;

	jls_pkg::state_t state_q, state_d;

	logic [3:0]  dim_q;
	logic [30:0] tol_q;
	logic [15:0] lim_q;

	logic signed [31:0] rhs_q   [MD];
	logic signed [31:0] x_cur_q [MD];
	logic signed [31:0] x_nxt_q [MD];

	logic [IW-1:0] i_q, j_q;
	logic [15:0]   sweep_q;
	logic [31:0]   big_q;
	logic [1:0]    stat_q;
	logic          zd_q;
	logic signed [31:0] diag_q;
	logic signed [63:0] prod_s1;
	logic signed [AC-1:0] acc_q;
	logic          neg_q;

	logic [CW-1:0] n_eff;
	logic [IW-1:0] last_idx;
	logic          accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic signed [31:0] ram_rdata;
	logic          div_start;
	logic          div_done;
	logic [DW-1:0] div_dividend, div_quot;
	logic [31:0]   div_divisor;

	logic signed [AC:0]  num_wide;
	logic signed [31:0]  num;
	logic [31:0]         num_mag;
	logic signed [DW:0]  q_signed;
	logic signed [31:0]  x_new;
	logic signed [32:0]  diff;
	logic [32:0]         diff_abs;
	logic [31:0]         change;
	logic [16:0]         sweep_inc;

	// Effective dimension: zero acts as one, large values clamp to the maximum.
	always_comb begin
		if (dim_q == 4'd0) begin
			n_eff = CW'(1);
		end else if (int'(dim_q) > MD) begin
			n_eff = CW'(MD);
		end else begin
			n_eff = CW'(dim_q);
		end
	end
	assign last_idx = IW'(n_eff - CW'(1));

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Matrix store write port.
	assign ram_we    = accept && (cmd == jls_pkg::CMD_LOAD_MAT) &&
		(int'(row) < MD) && (int'(col) < MD);
	assign ram_waddr = AW'(int'(row) * MD + int'(col));

	jls_ram #(.WIDTH(32), .DEPTH(MD * MD)) u_matrix (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Numerator, saturated to 32 bits, and divider operands.
	always_comb begin
		num_wide = (AC+1)'(rhs_q[i_q]) - (AC+1)'(acc_q);
		if (num_wide > (AC+1)'(64'sh7FFFFFFF)) begin
			num = 32'sh7FFFFFFF;
		end else if (num_wide < -(AC+1)'(64'sh80000000)) begin
			num = 32'sh80000000;
		end else begin
			num = 32'(num_wide);
		end
		num_mag      = num[31] ? 32'(-num) : 32'(num);
		div_dividend = {num_mag, FB'(0)};
		div_divisor  = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
	end

	jls_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Signed quotient, saturation and the change of the element.
	always_comb begin
		q_signed = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
		if (q_signed > (DW+1)'(64'sh7FFFFFFF)) begin
			x_new = 32'sh7FFFFFFF;
		end else if (q_signed < -(DW+1)'(64'sh80000000)) begin
			x_new = 32'sh80000000;
		end else begin
			x_new = 32'(q_signed);
		end
		diff     = 33'(x_new) - 33'(x_cur_q[i_q]);
		diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
		change   = diff_abs[32] ? 32'hFFFFFFFF : diff_abs[31:0];
		sweep_inc = {1'b0, sweep_q} + 17'd1;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			jls_pkg::ST_IDLE: begin
				if (accept && cmd == jls_pkg::CMD_SOLVE) begin
					state_d = jls_pkg::ST_DG_ADDR;
				end
			end
			jls_pkg::ST_DG_ADDR: state_d = jls_pkg::ST_DG_CHK;
			jls_pkg::ST_DG_CHK: begin
				if (ram_rdata == 32'sd0) begin
					state_d = jls_pkg::ST_OUT;
				end else if (i_q == last_idx) begin
					state_d = jls_pkg::ST_MAC_ADDR;
				end else begin
					state_d = jls_pkg::ST_DG_ADDR;
				end
			end
			jls_pkg::ST_MAC_ADDR: state_d = jls_pkg::ST_MAC_MUL;
			jls_pkg::ST_MAC_MUL:  state_d = jls_pkg::ST_MAC_ACC;
			jls_pkg::ST_MAC_ACC: begin
				state_d = (j_q == last_idx) ? jls_pkg::ST_NUM : jls_pkg::ST_MAC_ADDR;
			end
			jls_pkg::ST_NUM: state_d = jls_pkg::ST_DIV;
			jls_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = jls_pkg::ST_UPD;
				end
			end
			jls_pkg::ST_UPD: begin
				state_d = (i_q == last_idx) ? jls_pkg::ST_SWEEP_END : jls_pkg::ST_MAC_ADDR;
			end
			jls_pkg::ST_SWEEP_END: begin
				if (big_q <= {1'b0, tol_q} || sweep_inc >= {1'b0, lim_q}) begin
					state_d = jls_pkg::ST_OUT;
				end else begin
					state_d = jls_pkg::ST_MAC_ADDR;
				end
			end
			jls_pkg::ST_OUT: begin
				if (i_q == last_idx) begin
					state_d = jls_pkg::ST_IDLE;
				end
			end
			default: state_d = jls_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy      = 1'b1;
		done      = 1'b0;
		div_start = 1'b0;
		ram_raddr = AW'(int'(i_q) * MD + int'(j_q));
		case (state_q)
			jls_pkg::ST_IDLE:    busy = 1'b0;
			jls_pkg::ST_DG_ADDR: ram_raddr = AW'(int'(i_q) * MD + int'(i_q));
			jls_pkg::ST_NUM:     div_start = 1'b1;
			jls_pkg::ST_OUT:     done = 1'b1;
			default: begin
			end
		endcase
	end

	assign index    = 3'(i_q);
	assign solution = zd_q ? 32'sd0 : x_cur_q[i_q];
	assign status   = stat_q;
	assign last     = (i_q == last_idx);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jls_pkg::ST_IDLE;
			dim_q   <= 4'd3;
			tol_q   <= 31'd66;
			lim_q   <= 16'd1000;
			i_q     <= '0;
			j_q     <= '0;
			sweep_q <= '0;
			big_q   <= '0;
			stat_q  <= jls_pkg::STAT_CONVERGED;
			zd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					jls_pkg::REG_DIMENSION: dim_q <= cfg_data[3:0];
					jls_pkg::REG_TOLERANCE: tol_q <= cfg_data[30:0];
					jls_pkg::REG_ITER_LIM:  lim_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				jls_pkg::ST_IDLE: begin
					i_q     <= '0;
					j_q     <= '0;
					sweep_q <= '0;
					big_q   <= '0;
					zd_q    <= 1'b0;
				end
				jls_pkg::ST_DG_CHK: begin
					if (ram_rdata == 32'sd0) begin
						zd_q   <= 1'b1;
						stat_q <= jls_pkg::STAT_ZERO_DIAG;
						i_q    <= '0;
					end else if (i_q == last_idx) begin
						i_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				jls_pkg::ST_MAC_ACC: begin
					j_q <= (j_q == last_idx) ? '0 : j_q + 1'b1;
				end
				jls_pkg::ST_UPD: begin
					if (change > big_q) begin
						big_q <= change;
					end
					i_q <= (i_q == last_idx) ? '0 : i_q + 1'b1;
				end
				jls_pkg::ST_SWEEP_END: begin
					sweep_q <= sweep_inc[15:0];
					big_q   <= '0;
					if (big_q <= {1'b0, tol_q}) begin
						stat_q <= jls_pkg::STAT_CONVERGED;
					end else begin
						stat_q <= jls_pkg::STAT_LIMIT;
					end
				end
				jls_pkg::ST_OUT: begin
					i_q <= (i_q == last_idx) ? '0 : i_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers: vectors, product and accumulator.
	always_ff @(posedge clk) begin
		if (accept && cmd == jls_pkg::CMD_LOAD_VEC && int'(row) < MD) begin
			rhs_q[IW'(row)] <= value;
		end
		if (state_q == jls_pkg::ST_IDLE && accept && cmd == jls_pkg::CMD_SOLVE) begin
			for (int k = 0; k < MD; k++) begin
				x_cur_q[k] <= '0;
				x_nxt_q[k] <= '0;
			end
		end
		if (state_q == jls_pkg::ST_MAC_ADDR && j_q == '0) begin
			acc_q <= '0;
		end
		if (state_q == jls_pkg::ST_MAC_MUL) begin
			prod_s1 <= 64'(ram_rdata) * 64'(x_cur_q[j_q]);
			if (j_q == i_q) begin
				diag_q <= ram_rdata;
			end
		end
		if (state_q == jls_pkg::ST_MAC_ACC && j_q != i_q) begin
			acc_q <= acc_q + AC'(prod_s1 >>> FB);
		end
		if (state_q == jls_pkg::ST_NUM) begin
			neg_q <= num[31] ^ diag_q[31];
		end
		if (state_q == jls_pkg::ST_UPD) begin
			x_nxt_q[i_q] <= x_new;
		end
		if (state_q == jls_pkg::ST_SWEEP_END) begin
			for (int k = 0; k < MD; k++) begin
				x_cur_q[k] <= x_nxt_q[k];
			end
		end
	end

endmodule
`default_nettype wire

[verif/jacobi_linear_solver_tb.sv]
`timescale 1ns / 100ps
module jacobi_linear_solver_tb;

	localparam int MAX_DIM = jls_pkg::MAX_DIM;
	localparam int FRAC_BITS = jls_pkg::FRAC_BITS;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 40;

	typedef enum logic {OP_CMD, OP_CFG} op_kind_t;

	typedef struct {
		op_kind_t          kind;
		logic [1:0]        cmd;
		logic [2:0]        row;
		logic [2:0]        col;
		logic signed [31:0] value;
		logic [1:0]        cfg_index;
		logic [31:0]       cfg_data;
	} op_t;

	typedef struct {
		logic [2:0]         index;
		logic signed [31:0] solution;
		logic [1:0]         status;
		logic               last;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] cmd = '0;
	logic [2:0] row = '0;
	logic [2:0] col = '0;
	logic signed [31:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	logic [2:0] index;
	logic signed [31:0] solution;
	logic [1:0] status;
	logic last;

	op_t pending_q[$];
	solution_t solution_q[$];
	int fail_count = 0;

	// Shadow copy of the solver state.
	logic [3:0]  dim_reg = 4'd3;
	logic [30:0] tol_reg = 31'd66;
	logic [15:0] lim_reg = 16'd1000;
	logic signed [31:0] mat_m[MAX_DIM*MAX_DIM];
	logic signed [31:0] rhs_m[MAX_DIM];

	jacobi_linear_solver uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .row(row), .col(col), .value(value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .index(index), .solution(solution),
		.status(status), .last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Runs Jacobi sweeps on the shadow stores and queues one beat per unknown.
	task automatic solve_and_expect();
		int n;
		bit zero_diag;
		longint x_cur[MAX_DIM];
		longint x_nxt[MAX_DIM];
		longint acc, num, q, d;
		longint unsigned big, ch;
		int sweeps;
		logic [1:0] stat;
		solution_t s;
		n = (dim_reg == 0) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
		zero_diag = 0;
		sweeps = 0;
		for (int i = 0; i < MAX_DIM; i++) begin
			x_cur[i] = 0;
			x_nxt[i] = 0;
		end
		for (int i = 0; i < n; i++)
			if (mat_m[i*MAX_DIM+i] == 0) zero_diag = 1;
		if (zero_diag) begin
			stat = jls_pkg::STAT_ZERO_DIAG;
		end else begin
			forever begin
				big = 0;
				for (int i = 0; i < n; i++) begin
					acc = 0;
					// Arithmetic shift of the exact product floors it.
					for (int j = 0; j < n; j++)
						if (j != i)
							acc += (longint'(mat_m[i*MAX_DIM+j]) * x_cur[j]) >>> FRAC_BITS;
					num = sat32(longint'(rhs_m[i]) - acc);
					q = (num * (64'sd1 << FRAC_BITS)) / longint'(mat_m[i*MAX_DIM+i]);
					x_nxt[i] = sat32(q);
					d = x_nxt[i] - x_cur[i];
					ch = (d < 0) ? -d : d;
					if (ch > 64'hFFFF_FFFF) ch = 64'hFFFF_FFFF;
					if (ch > big) big = ch;
				end
				for (int i = 0; i < n; i++) x_cur[i] = x_nxt[i];
				sweeps++;
				if (big <= tol_reg) begin
					stat = jls_pkg::STAT_CONVERGED;
					break;
				end
				if (sweeps >= ((lim_reg == 0) ? 1 : int'(lim_reg))) begin
					stat = jls_pkg::STAT_LIMIT;
					break;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			s.index = i[2:0];
			s.solution = zero_diag ? 32'sd0 : x_nxt[i][31:0];
			s.status = stat;
			s.last = (i + 1 == n);
			solution_q.push_back(s);
		end
	endtask

	task automatic apply_item(op_t it);
		case (it.cmd)
			jls_pkg::CMD_LOAD_MAT: mat_m[it.row*MAX_DIM+it.col] = it.value;
			jls_pkg::CMD_LOAD_VEC: rhs_m[it.row] = it.value;
			jls_pkg::CMD_SOLVE: solve_and_expect();
			default: ;
		endcase
	endtask

	task automatic apply_cfg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			jls_pkg::REG_DIMENSION: dim_reg = data[3:0];
			jls_pkg::REG_TOLERANCE: tol_reg = data[30:0];
			jls_pkg::REG_ITER_LIM: lim_reg = data[15:0];
			default: ;
		endcase
	endtask

	function automatic op_t cmd_op(logic [1:0] c, logic [2:0] r, logic [2:0] k,
			logic [31:0] v);
		op_t o;
		o.kind = OP_CMD;
		o.cmd = c;
		o.row = r;
		o.col = k;
		o.value = v;
		o.cfg_index = '0;
		o.cfg_data = '0;
		return o;
	endfunction

	function automatic op_t cfg_op(logic [1:0] idx, logic [31:0] data);
		op_t o;
		o = cmd_op(CMD_UNUSED, 3'd0, 3'd0, 32'd0);
		o.kind = OP_CFG;
		o.cfg_index = idx;
		o.cfg_data = data;
		return o;
	endfunction

	function automatic logic [31:0] signed_range(int unsigned lo, int unsigned hi);
		logic [31:0] m;
		m = $urandom_range(hi, lo);
		return $urandom_range(1, 0) ? -m : m;
	endfunction

	// Driver: one beat per handshake; config only once the block has gone quiet.
	int gap = 0;
	int quiet = 0;
	always @(posedge clk) begin
		logic start_n, cfgv_n;
		op_t it;
		start_n = start;
		cfgv_n = cfg_valid;
		if (arst_n) begin
			if (start && !busy) begin
				apply_item('{OP_CMD, cmd, row, col, value, 2'd0, 32'd0});
				start_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_cfg(cfg_index, cfg_data);
				cfgv_n = 1'b0;
			end
			if (start || cfg_valid || busy || done || solution_q.size() != 0)
				quiet = 0;
			else
				quiet++;
			if (gap > 0) begin
				gap--;
			end else if (!start_n && !cfgv_n && pending_q.size() != 0) begin
				it = pending_q[0];
				if (it.kind == OP_CMD) begin
					void'(pending_q.pop_front());
					cmd <= it.cmd;
					row <= it.row;
					col <= it.col;
					value <= it.value;
					start_n = 1'b1;
				end else if (quiet >= QUIET_CYCLES) begin
					void'(pending_q.pop_front());
					cfg_index <= it.cfg_index;
					cfg_data <= it.cfg_data;
					cfgv_n = 1'b1;
				end
				if (pending_q.size() > 40 && $urandom_range(3, 0) == 0)
					gap = $urandom_range(14, 1);
			end
		end
		start <= start_n;
		cfg_valid <= cfgv_n;
	end

	// Monitor: every result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		solution_t e;
		if (arst_n && done) begin
			if (solution_q.size() == 0) begin
				$error("unexpected result beat index=%0d solution=%0d", index, solution);
				fail_count++;
			end else begin
				e = solution_q.pop_front();
				if (index !== e.index) begin
					$error("index: expected %0d, actual %0d", e.index, index);
					fail_count++;
				end
				if (solution !== e.solution) begin
					$error("solution: expected %0d, actual %0d", e.solution, solution);
					fail_count++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					fail_count++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, last);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int count, n;
		bit dominant;
		for (int i = 0; i < MAX_DIM*MAX_DIM; i++) mat_m[i] = 0;
		for (int i = 0; i < MAX_DIM; i++) rhs_m[i] = 0;

		// Fill every store entry so that no solve reads an unwritten one.
		for (int r = 0; r < MAX_DIM; r++) begin
			for (int k = 0; k < MAX_DIM; k++)
				pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'(r), 3'(k),
					(r == k) ? 32'h0001_0000 * 32'(r + 2) : 32'd0));
			pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_VEC, 3'(r), 3'd0, $urandom()));
		end

		// Directed: extremes of the registers and each corner case.
		pending_q.push_back(cfg_op(jls_pkg::REG_ITER_LIM, 32'hABCD_FFFF));
		pending_q.push_back(cfg_op(jls_pkg::REG_TOLERANCE, 32'h0000_0000));
		pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION, 32'h0000_0008));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		pending_q.push_back(cfg_op(jls_pkg::REG_TOLERANCE, 32'hFFFF_FFFF));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd7, 3'd7, 32'hFFFF_FFFF));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'd0, 3'd0, 32'h7FFF_FFFF));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'd0, 3'd1, 32'h8000_0000));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'd1, 3'd0, 32'h7FFF_FFFF));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_VEC, 3'd0, 3'd5, 32'h7FFF_FFFF));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_VEC, 3'd1, 3'd2, 32'h8000_0000));
		pending_q.push_back(cfg_op(jls_pkg::REG_TOLERANCE, 32'h0000_0000));
		pending_q.push_back(cfg_op(jls_pkg::REG_ITER_LIM, 32'h5432_0001));
		pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION, 32'hFFFF_FFF2));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		// A zero limit still runs one sweep.
		pending_q.push_back(cfg_op(jls_pkg::REG_ITER_LIM, 32'h0000_0000));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		// Dimension zero acts as one, oversize acts as the maximum.
		pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION, 32'h0000_0000));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		pending_q.push_back(cfg_op(jls_pkg::REG_ITER_LIM, 32'h0000_0003));
		pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION, 32'h0000_000F));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		// A zero diagonal skips the sweeps; an unknown command is dropped.
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'd1, 3'd1, 32'h0000_0000));
		pending_q.push_back(cmd_op(CMD_UNUSED, 3'd3, 3'd4, 32'h1234_5678));
		pending_q.push_back(cfg_op(REG_UNUSED, 32'hFFFF_FFFF));
		pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION, 32'h0000_0002));
		pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'd0, 3'd0, 32'd0));
		pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'd1, 3'd1, 32'h0002_0000));

		// Random phases: mostly well-formed loads of a system followed by a solve.
		count = 0;
		while (count < 375) begin
			n = ($urandom_range(9, 0) < 7) ? $urandom_range(4, 1) : $urandom_range(15, 0);
			pending_q.push_back(cfg_op(jls_pkg::REG_DIMENSION,
				{28'($urandom_range(32'h0FFF_FFFF, 0)), n[3:0]}));
			pending_q.push_back(cfg_op(jls_pkg::REG_TOLERANCE, ($urandom_range(7, 0) == 0) ?
				$urandom() : {1'($urandom_range(1, 0)),
				31'($urandom_range(32'h0002_0000, 0))}));
			pending_q.push_back(cfg_op(jls_pkg::REG_ITER_LIM,
				{16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(10, 1))}));
			n = (n == 0) ? 1 : (n > MAX_DIM) ? MAX_DIM : n;
			repeat ($urandom_range(3, 1)) begin
				dominant = ($urandom_range(4, 0) != 0);
				for (int r = 0; r < n; r++) begin
					for (int k = 0; k < n; k++) begin
						if ($urandom_range(9, 0) == 0) continue;
						if (!dominant)
							pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'(r), 3'(k),
								$urandom()));
						else if (r == k)
							pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'(r), 3'(k),
								($urandom_range(30, 0) == 0) ? 32'd0 :
								signed_range(32'h0002_0000, 32'h0010_0000)));
						else
							pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_MAT, 3'(r), 3'(k),
								signed_range(0, 32'h0000_4000)));
						count++;
					end
					pending_q.push_back(cmd_op(jls_pkg::CMD_LOAD_VEC, 3'(r), 3'($urandom()),
						dominant ? signed_range(0, 32'h0100_0000) : $urandom()));
					count++;
				end
				// Occasional noise between the loads and the solve.
				if ($urandom_range(3, 0) == 0) begin
					repeat ($urandom_range(4, 1)) begin
						pending_q.push_back(cmd_op($urandom_range(3, 0) == 2 ? CMD_UNUSED :
							2'($urandom_range(3, 0)), 3'($urandom()), 3'($urandom()),
							$urandom()));
						count++;
					end
				end
				pending_q.push_back(cmd_op(jls_pkg::CMD_SOLVE, 3'($urandom()), 3'($urandom()),
					$urandom()));
				count++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() != 0 || start || cfg_valid || solution_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && solution_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/jls_pkg.sv
hw/rtl/jls_ram.sv
hw/rtl/jls_divider.sv
hw/rtl/jacobi_linear_solver.sv
verif/jacobi_linear_solver_tb.sv
